// ===== rtl/cmr_pkg.sv =====
// Chunked message reassembler: shared package.
// Word types for both channels, status and class codes, field widths and defaults.
// No dependencies.
`timescale 1ns / 1ps

package cmr_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 11;
  localparam int LEN_W   = 11;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 9;

  // Defaults
  localparam int                BUF_DEPTH_DEF = 2048;
  localparam logic [BYTE_W-1:0] CHUNK_MARK    = 8'hAA;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd5000;

  // Input word modes
  localparam logic MODE_PKT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Result word kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_CHUNK_STORED = 3'd0,
    ST_CHUNK_DONE   = 3'd1,
    ST_PLAIN_DONE   = 3'd2,
    ST_ORPHAN       = 3'd3,
    ST_OUT_OF_ORDER = 3'd4,
    ST_OVERFLOW     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CLS_UNDECIDED,
    CLS_CHUNK,
    CLS_PLAIN
  } pkt_class_e;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] pkt_byte;
    logic              pkt_last;
    logic [TIME_W-1:0] now_ms;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [ST_W-1:0]   status;
    logic              timed_out;
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] read_data;
  } out_item_t;

endpackage

// ===== rtl/cmr_ram.sv =====
// Chunked message reassembler: generic single-port-write, registered-read RAM.
// One write and one read per cycle; read data updates only on a read enable.
// No dependencies.
`timescale 1ns / 1ps

module cmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/chunked_message_reassembler_top.sv =====
// Chunked message reassembler, top level. Depends on cmr_pkg and cmr_ram.
// Link bytes come in one word per cycle; a packet of three or more bytes led by 0xAA is a
// chunk (index, total, payload) that is checked for timeout, orphan, order and overflow and
// appended to the assembly; any other packet is written straight into the message store,
// cut to BUF_DEPTH-1 bytes. Every packet end gives a status word and every read request a
// read word. The block takes one input word per clock while no held-back result stalls it:
// each word does one update of the assembly registers and at most one write into one of
// two BUF_DEPTH x 8 memory banks. Completing a chunked message flips which bank is the
// message store, so nothing is copied. A result passes the result register (memory read),
// then the output register; bytes that end no packet are taken even while results wait.
// Memory contents need no clearing after reset, so the block is ready at once.
`timescale 1ns / 1ps

module chunked_message_reassembler_top #(
  parameter int BUF_DEPTH = cmr_pkg::BUF_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cmr_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cmr_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [cmr_pkg::TMO_W-1:0]        cfg_wdata_i
);
  import cmr_pkg::*;

  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam int POS_W  = ADDR_W + 1;
  localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  localparam logic [POS_W-1:0] POS_PLAIN_MAX = POS_W'(BUF_DEPTH - 1);
  localparam logic [POS_W-1:0] POS_LEN_CAP   = POS_W'(BUF_DEPTH - 2);
  localparam logic [POS_W:0]   DEPTH_WIDE    = (POS_W + 1)'(BUF_DEPTH);

  // Result held between acceptance and the output register
  typedef struct packed {
    logic              kind;
    status_e           status;
    logic              timed_out;
    logic [LEN_W-1:0]  msg_len;
    logic              rd_hit;
    logic              rd_ovr;
    logic              rd_bank;
  } rslt_t;

  // Assembly and packet state
  logic [POS_W-1:0]  pos_q, pos_d;
  pkt_class_e        class_q, class_d;
  logic [BYTE_W-1:0] hdr_idx_q, hdr_idx_d;
  logic [BYTE_W-1:0] hdr_tot_q, hdr_tot_d;
  logic [BYTE_W-1:0] exp_q, exp_d;
  logic [CNT_W-1:0]  chunks_q, chunks_d;
  logic [ADDR_W-1:0] asm_len_q, asm_len_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [ADDR_W-1:0] msg_len_q, msg_len_d;
  logic [TMO_W-1:0]  timeout_q, timeout_d;
  logic              bank_q, bank_d;
  logic              ovr0_q, ovr0_d;

  // Pipeline
  logic              s1_valid_q, s1_valid_d;
  rslt_t             s1_q, s1_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // Handshake
  logic              has_result, s1_move, in_acc;

  // Packet decode
  pkt_class_e        class_now;
  logic [POS_W-1:0]  pos_inc;
  logic [ADDR_W-1:0] plain_len;
  logic [ADDR_W-1:0] ck_base;
  logic [POS_W:0]    ck_addr;
  logic              rd_hit;

  // Chunk decision
  logic [BYTE_W-1:0] fin_tot;
  logic [POS_W-1:0]  fin_dlen;
  logic [TIME_W-1:0] fin_age;
  logic              fin_tmo;
  logic [BYTE_W-1:0] fin_e2;
  logic [CNT_W-1:0]  fin_c2, fin_c3;
  logic [ADDR_W-1:0] fin_a2;
  logic [POS_W:0]    fin_sum;
  status_e           fin_status;
  logic [BYTE_W-1:0] fin_exp;
  logic [CNT_W-1:0]  fin_chunks;
  logic [ADDR_W-1:0] fin_asm;
  logic              fin_done;

  // Memory access
  logic              wr_en, wr_to_msg, wr_sel, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [BYTE_W-1:0] rdata0, rdata1;

  // Handshake: a byte that ends no packet never needs the result path
  assign has_result = (in_data_i.mode == MODE_READ) || in_data_i.pkt_last;
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move || !has_result;
  assign in_acc     = in_valid_i && in_ready_o;

  // Packet decode helpers
  assign class_now = (pos_q == '0) ?
                     ((in_data_i.pkt_byte == CHUNK_MARK) ? CLS_CHUNK : CLS_PLAIN) : class_q;
  assign pos_inc   = (&pos_q) ? pos_q : pos_q + POS_W'(1);
  assign plain_len = (pos_q < POS_LEN_CAP) ? ADDR_W'(pos_q + POS_W'(1))
                                           : ADDR_W'(BUF_DEPTH - 1);
  assign ck_base   = (hdr_idx_q == '0) ? '0 : asm_len_q;
  assign ck_addr   = (POS_W + 1)'(ck_base) + (POS_W + 1)'(pos_q - POS_W'(3));
  assign rd_hit    = CMP_W'(in_data_i.read_index) < CMP_W'(msg_len_q);
  assign rd_addr   = ADDR_W'(in_data_i.read_index);

  // Chunk decision at the last byte of a chunk packet
  always_comb begin
    fin_tot  = (pos_q == POS_W'(2)) ? in_data_i.pkt_byte : hdr_tot_q;
    fin_dlen = pos_q - POS_W'(2);
    fin_age  = in_data_i.now_ms - start_q;
    fin_tmo  = (exp_q != '0) && (fin_age > TIME_W'(timeout_q));
    // index zero restarts; a timeout drops the open assembly first
    if (hdr_idx_q == '0) begin
      fin_e2 = fin_tot;
      fin_c2 = '0;
      fin_a2 = '0;
    end else if (fin_tmo) begin
      fin_e2 = '0;
      fin_c2 = '0;
      fin_a2 = '0;
    end else begin
      fin_e2 = exp_q;
      fin_c2 = chunks_q;
      fin_a2 = asm_len_q;
    end
    fin_sum    = (POS_W + 1)'(fin_a2) + (POS_W + 1)'(fin_dlen);
    fin_c3     = fin_c2 + CNT_W'(1);
    fin_status = ST_CHUNK_STORED;
    fin_exp    = '0;
    fin_chunks = '0;
    fin_asm    = '0;
    fin_done   = 1'b0;
    if ((fin_tot != fin_e2) || (CNT_W'(hdr_idx_q) != fin_c2)) begin
      if ((fin_e2 == '0) && (hdr_idx_q != '0)) begin
        fin_status = ST_ORPHAN;
      end else begin
        fin_status = ST_OUT_OF_ORDER;
        fin_exp    = fin_e2;
        fin_chunks = fin_c2;
        fin_asm    = fin_a2;
      end
    end else if (fin_sum >= DEPTH_WIDE) begin
      fin_status = ST_OVERFLOW;
    end else if (fin_c3 >= CNT_W'(fin_e2)) begin
      fin_status = ST_CHUNK_DONE;
      fin_asm    = ADDR_W'(fin_sum);
      fin_done   = 1'b1;
    end else begin
      fin_status = ST_CHUNK_STORED;
      fin_exp    = fin_e2;
      fin_chunks = fin_c3;
      fin_asm    = ADDR_W'(fin_sum);
    end
  end

  // Per-word state update and memory request
  always_comb begin
    pos_d     = pos_q;
    class_d   = class_q;
    hdr_idx_d = hdr_idx_q;
    hdr_tot_d = hdr_tot_q;
    exp_d     = exp_q;
    chunks_d  = chunks_q;
    asm_len_d = asm_len_q;
    start_d   = start_q;
    msg_len_d = msg_len_q;
    bank_d    = bank_q;
    ovr0_d    = ovr0_q;
    wr_en     = 1'b0;
    wr_to_msg = 1'b0;
    wr_addr   = '0;
    rd_en     = 1'b0;
    s1_d      = '0;
    s1_d.kind = KIND_STATUS;
    if (in_acc) begin
      if (in_data_i.mode == MODE_READ) begin
        // read request: message bank read; the output word is completed from the read data
        rd_en          = rd_hit;
        s1_d.kind      = KIND_READ;
        s1_d.msg_len   = LEN_W'(msg_len_q);
        s1_d.rd_hit    = rd_hit;
        s1_d.rd_ovr    = ovr0_q && (in_data_i.read_index == '0);
        s1_d.rd_bank   = bank_q;
      end else begin
        // byte store / header capture
        if (class_now == CLS_PLAIN) begin
          if (pos_q < POS_PLAIN_MAX) begin
            wr_en     = 1'b1;
            wr_to_msg = 1'b1;
            wr_addr   = ADDR_W'(pos_q);
            if (pos_q == '0) begin
              ovr0_d = 1'b0;
            end
          end
        end else if (pos_q == POS_W'(1)) begin
          hdr_idx_d = in_data_i.pkt_byte;
          hdr_tot_d = '0;
        end else if (pos_q == POS_W'(2)) begin
          hdr_tot_d = in_data_i.pkt_byte;
        end else if (pos_q >= POS_W'(3)) begin
          if (ck_addr < DEPTH_WIDE) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(ck_addr);
          end
        end
        if (!in_data_i.pkt_last) begin
          pos_d   = pos_inc;
          class_d = class_now;
        end else begin
          // packet end
          pos_d   = '0;
          class_d = CLS_UNDECIDED;
          if ((class_now == CLS_CHUNK) && (pos_q < POS_W'(2))) begin
            // short 0xAA packet: entry 0 reads as the mark, entry 1 gets the byte
            ovr0_d       = 1'b1;
            msg_len_d    = ADDR_W'(pos_q) + ADDR_W'(1);
            s1_d.status  = ST_PLAIN_DONE;
            s1_d.msg_len = LEN_W'(ADDR_W'(pos_q) + ADDR_W'(1));
            if (pos_q == POS_W'(1)) begin
              wr_en     = 1'b1;
              wr_to_msg = 1'b1;
              wr_addr   = ADDR_W'(1);
            end
          end else if (class_now == CLS_CHUNK) begin
            exp_d          = fin_exp;
            chunks_d       = fin_chunks;
            asm_len_d      = fin_done ? '0 : fin_asm;
            start_d        = (hdr_idx_q == '0) ? in_data_i.now_ms : start_q;
            s1_d.status    = fin_status;
            s1_d.timed_out = fin_tmo;
            if (fin_done) begin
              // assembly bank becomes the message store
              msg_len_d    = fin_asm;
              s1_d.msg_len = LEN_W'(fin_asm);
              bank_d       = !bank_q;
              ovr0_d       = 1'b0;
            end
          end else begin
            msg_len_d    = plain_len;
            s1_d.status  = ST_PLAIN_DONE;
            s1_d.msg_len = LEN_W'(plain_len);
          end
        end
      end
    end
  end

  // Config register
  assign timeout_d = cfg_we_i ? cfg_wdata_i : timeout_q;

  // Result pipeline control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc && has_result) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Output word assembly from the held result and the read port
  always_comb begin
    out_d.kind      = s1_q.kind;
    out_d.status    = s1_q.status;
    out_d.timed_out = s1_q.timed_out;
    out_d.msg_len   = s1_q.msg_len;
    if (!s1_q.rd_hit) begin
      out_d.read_data = '0;
    end else if (s1_q.rd_ovr) begin
      out_d.read_data = CHUNK_MARK;
    end else begin
      out_d.read_data = s1_q.rd_bank ? rdata1 : rdata0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      class_q     <= CLS_UNDECIDED;
      hdr_idx_q   <= '0;
      hdr_tot_q   <= '0;
      exp_q       <= '0;
      chunks_q    <= '0;
      asm_len_q   <= '0;
      start_q     <= '0;
      msg_len_q   <= '0;
      timeout_q   <= TIMEOUT_RESET;
      bank_q      <= 1'b0;
      ovr0_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      class_q     <= class_d;
      hdr_idx_q   <= hdr_idx_d;
      hdr_tot_q   <= hdr_tot_d;
      exp_q       <= exp_d;
      chunks_q    <= chunks_d;
      asm_len_q   <= asm_len_d;
      start_q     <= start_d;
      msg_len_q   <= msg_len_d;
      timeout_q   <= timeout_d;
      bank_q      <= bank_d;
      ovr0_q      <= ovr0_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && has_result) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Two banks: one holds the message, the other the assembly
  assign wr_sel = wr_to_msg ? bank_q : !bank_q;

  cmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !wr_sel),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.pkt_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  cmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && wr_sel),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.pkt_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

endmodule

// ===== rtl/cmr_checker.sv =====
// Chunked message reassembler: port-level checker and its bind to the top level.
// Depends on cmr_pkg and chunked_message_reassembler_top.
`timescale 1ns / 1ps

module cmr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input cmr_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input cmr_pkg::out_item_t out_data_o
);
  import cmr_pkg::*;

  // Bytes that end no packet are always taken
  a_mid_byte_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (in_data_i.mode == MODE_PKT) && !in_data_i.pkt_last |-> in_ready_o)
    else $error("mid-packet byte stalled");

  // Input only stalls when the output is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted result-producing word through the result and output registers
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o &&
      ((in_data_i.mode == MODE_READ) || in_data_i.pkt_last), 2))
    else $error("result word without a source word");

  // Held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

endmodule

bind chunked_message_reassembler_top cmr_checker u_cmr_checker (.*);
